[design/buzz_pkg.sv]
package buzz_pkg;

   localparam int unsigned FreqW   = 13;
   localparam int unsigned MsW     = 12;
   localparam int unsigned WorkW   = 17;
   localparam logic [FreqW-1:0] FreqMax = 13'd8191;

   // x * 205 >> 11 equals x / 10 for every 8-bit x
   localparam logic [15:0] Recip10 = 16'd205;
   localparam int unsigned Recip10Shift = 11;

   localparam logic [2:0] DivMax = 3'd6;

   localparam logic [3:0] RegLow  = 4'd1;
   localparam logic [3:0] RegHigh = 4'd3;

   localparam logic [0:0] CsrKeyShift    = 1'b0;
   localparam logic [0:0] CsrOctaveShift = 1'b1;

   typedef struct packed {
      logic [1:0] hund;
      logic [3:0] tens;
      logic [3:0] ones;
   } digits_type;

   function automatic digits_type split_digits(input logic [7:0] x);
      logic [15:0] prod;
      logic [4:0]  q;
      logic [7:0]  qx10;
      digits_type  d;
      prod = 16'(x) * Recip10;
      q    = prod[Recip10Shift+4:Recip10Shift];
      qx10 = 8'(q) * 8'd10;
      d.ones = 4'(x - qx10);
      if (q >= 5'd20) begin
         d.hund = 2'd2;
         d.tens = 4'(q - 5'd20);
      end else if (q >= 5'd10) begin
         d.hund = 2'd1;
         d.tens = 4'(q - 5'd10);
      end else begin
         d.hund = 2'd0;
         d.tens = q[3:0];
      end
      return d;
   endfunction

   function automatic logic [8:0] base_freq(input logic [3:0] idx);
      logic [8:0] f;
      case (idx)
         4'd0:    f = 9'd262;
         4'd1:    f = 9'd277;
         4'd2:    f = 9'd294;
         4'd3:    f = 9'd311;
         4'd4:    f = 9'd330;
         4'd5:    f = 9'd349;
         4'd6:    f = 9'd369;
         4'd7:    f = 9'd392;
         4'd8:    f = 9'd415;
         4'd9:    f = 9'd440;
         4'd10:   f = 9'd466;
         4'd11:   f = 9'd494;
         default: f = 9'd262;
      endcase
      return f;
   endfunction

   // semitone of scale degrees 1..7; other codes are rests and never used
   function automatic logic [3:0] degree_semi(input logic [3:0] deg);
      logic [3:0] s;
      case (deg)
         4'd1:    s = 4'd0;
         4'd2:    s = 4'd2;
         4'd3:    s = 4'd4;
         4'd4:    s = 4'd5;
         4'd5:    s = 4'd7;
         4'd6:    s = 4'd9;
         4'd7:    s = 4'd11;
         default: s = 4'd0;
      endcase
      return s;
   endfunction

   // whole note 1600 ms >> n, optionally dotted (x3/2, truncated)
   function automatic logic [MsW-1:0] note_ms(input logic dotted, input logic [2:0] n);
      logic [MsW-1:0] len;
      case ({dotted, n})
         4'b0_000: len = 12'd1600;
         4'b0_001: len = 12'd800;
         4'b0_010: len = 12'd400;
         4'b0_011: len = 12'd200;
         4'b0_100: len = 12'd100;
         4'b0_101: len = 12'd50;
         4'b0_110: len = 12'd25;
         4'b1_000: len = 12'd2400;
         4'b1_001: len = 12'd1200;
         4'b1_010: len = 12'd600;
         4'b1_011: len = 12'd300;
         4'b1_100: len = 12'd150;
         4'b1_101: len = 12'd75;
         4'b1_110: len = 12'd37;
         default:  len = 12'd25;
      endcase
      return len;
   endfunction

   // staccato sounding time: note length * 4 / 5, truncated
   function automatic logic [MsW-1:0] stacc_len(input logic dotted, input logic [2:0] n);
      logic [MsW-1:0] len;
      case ({dotted, n})
         4'b0_000: len = 12'd1280;
         4'b0_001: len = 12'd640;
         4'b0_010: len = 12'd320;
         4'b0_011: len = 12'd160;
         4'b0_100: len = 12'd80;
         4'b0_101: len = 12'd40;
         4'b0_110: len = 12'd20;
         4'b1_000: len = 12'd1920;
         4'b1_001: len = 12'd960;
         4'b1_010: len = 12'd480;
         4'b1_011: len = 12'd240;
         4'b1_100: len = 12'd120;
         4'b1_101: len = 12'd60;
         4'b1_110: len = 12'd29;
         default:  len = 12'd20;
      endcase
      return len;
   endfunction

endpackage

[design/buzzer_note_decoder.sv]
// Note decoder for a buzzer: turns one note of numbered notation into a
// frequency and its sounding and silent times.
//
// req_ channel: one note per transfer, tdata = {length_code, tone_code}.
// rsp_ channel: one result per note, tdata = {silence_ms, sound_ms,
//    tone_freq_hz}, padded with zeros to 40 bits.
// csr_ channel: register writes (0 key_shift, 1 octave_shift), always
//    ready; write only while no note is in flight.
//
// rsp_tvalid rises after a req transfer once the note has passed the input
// register, one pass of digit split, table lookup and shifts, and then the
// result register. Throughput is one note per cycle while rsp_tready is high;
// both registers advance together and req_tready stays high while any stage
// is free. When rsp_tready is low the result holds, the input register fills,
// and then req_tready drops until the result is taken.
// Reset (synchronous) empties both stages and loads key_shift = 2,
// octave_shift = +1.
module buzzer_note_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] tone_code, [15:8] length_code
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [12:0] tone_freq_hz, [24:13] sound_ms,
                                    // [36:25] silence_ms, [39:37] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [3:0]  csr_data
);

   localparam int unsigned FW = buzz_pkg::FreqW;
   localparam int unsigned MW = buzz_pkg::MsW;
   localparam int unsigned WW = buzz_pkg::WorkW;

   logic [3:0]    key_ff, key_in;
   logic [2:0]    oct_ff, oct_in;

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    tone_ff, tone_in;
   logic [7:0]    len_ff, len_in;

   logic          out_valid_ff, out_valid_in;
   logic [FW-1:0] freq_ff, freq_in;
   logic [MW-1:0] sound_ff, sound_in;
   logic [MW-1:0] silence_ff, silence_in;

   logic          advance;

   buzz_pkg::digits_type tone_d, len_d;
   logic          rest;
   logic [4:0]    p_sum;
   logic          sharp_wrap;
   logic [3:0]    p_mod;
   logic [4:0]    j_sum;
   logic [1:0]    key_wrap;
   logic [3:0]    j_mod;
   logic [WW-1:0] f_key, f_oct, f_sharp, f_reg;
   logic [2:0]    oct_mag;
   logic [2:0]    div_n;
   logic          dotted;
   logic [MW-1:0] full_len, play_len;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, silence_ff, sound_ff, freq_ff};

   always_comb begin
      key_in = key_ff;
      oct_in = oct_ff;
      if (csr_valid) begin
         case (csr_index)
            buzz_pkg::CsrKeyShift:    key_in = csr_data;
            buzz_pkg::CsrOctaveShift: oct_in = csr_data[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      tone_in     = tone_ff;
      len_in      = len_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         tone_in     = req_tdata[7:0];
         len_in      = req_tdata[15:8];
      end
   end

   // decode of the registered note
   always_comb begin
      tone_d = buzz_pkg::split_digits(tone_ff);
      len_d  = buzz_pkg::split_digits(len_ff);
      rest   = (tone_d.ones == 4'd0) || (tone_d.ones > 4'd7);

      // semitone, sharp wrap, then key shift wrap (up to two octaves)
      p_sum      = 5'(buzz_pkg::degree_semi(tone_d.ones)) + 5'(tone_d.hund);
      sharp_wrap = (p_sum >= 5'd12);
      p_mod      = sharp_wrap ? 4'(p_sum - 5'd12) : p_sum[3:0];
      j_sum      = 5'(p_mod) + 5'(key_ff);
      if (j_sum >= 5'd24) begin
         key_wrap = 2'd2;
         j_mod    = 4'(j_sum - 5'd24);
      end else if (j_sum >= 5'd12) begin
         key_wrap = 2'd1;
         j_mod    = 4'(j_sum - 5'd12);
      end else begin
         key_wrap = 2'd0;
         j_mod    = j_sum[3:0];
      end
      f_key = WW'(buzz_pkg::base_freq(j_mod)) << key_wrap;

      // negative octave shift truncates before any later doubling
      oct_mag = 3'(-oct_ff);
      if (oct_ff[2])
         f_oct = f_key >> oct_mag;
      else
         f_oct = f_key << oct_ff[1:0];

      f_sharp = f_oct << sharp_wrap;
      if (tone_d.tens == buzz_pkg::RegLow)
         f_reg = f_sharp >> 1;
      else if (tone_d.tens == buzz_pkg::RegHigh)
         f_reg = f_sharp << 1;
      else
         f_reg = f_sharp;

      if (rest)
         freq_in = '0;
      else if (|f_reg[WW-1:FW])
         freq_in = buzz_pkg::FreqMax;
      else
         freq_in = f_reg[FW-1:0];

      div_n    = (len_d.ones > 4'(buzz_pkg::DivMax)) ? buzz_pkg::DivMax : len_d.ones[2:0];
      dotted   = (len_d.hund == 2'd1);
      full_len = buzz_pkg::note_ms(dotted, div_n);
      play_len = (len_d.tens == 4'd0) ? buzz_pkg::stacc_len(dotted, div_n) : full_len;
      sound_in   = rest ? '0 : play_len;
      silence_in = full_len - sound_in;
   end

   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= 4'd2;
         oct_ff       <= 3'd1;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         key_ff       <= key_in;
         oct_ff       <= oct_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tone_ff <= tone_in;
      len_ff  <= len_in;
      if (advance) begin
         freq_ff    <= freq_in;
         sound_ff   <= sound_in;
         silence_ff <= silence_in;
      end
   end

endmodule
